// ===== hw/rtl/tsdr_pkg.sv =====
package tsdr_pkg;

  // Request function: one scratchpad byte, or a report poll
  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_POLL = 1'b1
  } func_t;

  // Response kind: read finished, or report to send
  typedef enum logic {
    KIND_READ   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FAMILY  = 3'd0,
    CFG_OFFSET  = 3'd1,
    CFG_DELTA   = 3'd2,
    CFG_MIN_INT = 3'd3,
    CFG_MAX_INT = 3'd4,
    CFG_EMPTY   = 3'd5,
    CFG_ERROR   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  byte_value;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] temperature;
    logic               read_failed;
  } rsp_t;

  // Sensor family codes
  localparam logic [7:0] FAM_S20  = 8'h10;
  localparam logic [7:0] FAM_B20  = 8'h28;
  localparam logic [7:0] FAM_1822 = 8'h22;

  // Scratchpad byte positions
  localparam logic [3:0] SP_TEMP_LSB    = 4'd0;
  localparam logic [3:0] SP_TEMP_MSB    = 4'd1;
  localparam logic [3:0] SP_CONFIG      = 4'd4;
  localparam logic [3:0] SP_COUNT_REM   = 4'd6;
  localparam logic [3:0] SP_COUNT_PER_C = 4'd7;
  localparam logic [3:0] SP_CRC         = 4'd8;

  // Kept byte slots
  localparam int KB_LSB = 0;
  localparam int KB_MSB = 1;
  localparam int KB_CFG = 2;
  localparam int KB_REM = 3;
  localparam int KB_PER = 4;
  localparam int KB_NUM = 5;

  // Resolution codes in the config byte (bits 6:5)
  localparam logic [1:0] RES_9BIT  = 2'b00;
  localparam logic [1:0] RES_10BIT = 2'b01;
  localparam logic [1:0] RES_11BIT = 2'b10;

  localparam logic [7:0]  CRC_POLY      = 8'h8C;
  localparam logic [7:0]  S20_PER_C     = 8'h10;
  localparam logic [15:0] S20_EXT_MASK  = 16'hFFF0;
  localparam logic [15:0] S20_EXT_BIAS  = 16'd12;
  localparam logic [7:0]  OFFSET_ZERO   = 8'd127;
  localparam logic [25:0] MS_PER_S      = 26'd1000;
  localparam logic [11:0] TENTHS_PER_C  = 12'd10;
  localparam logic [1:0]  RETRY_MAX     = 2'd3;

  localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [15:0] TEMP_MIN = 16'sh8000;

  // Reset values of the registers
  localparam logic [7:0]  RST_FAMILY  = 8'd0;
  localparam logic [7:0]  RST_OFFSET  = 8'd127;
  localparam logic [11:0] RST_DELTA10 = 12'd50;
  localparam logic [25:0] RST_MIN_MS  = 26'd10000;
  localparam logic [25:0] RST_MAX_MS  = 26'd150000;
  localparam logic signed [15:0] RST_EMPTY = -16'sd32767;
  localparam logic signed [15:0] RST_ERROR = 16'sh8000;

  // Dallas CRC8 over one byte, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic       mix;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ data[i];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/tsdr_decode.sv =====
// Raw scratchpad to hundredths of a degree, by sensor family
module tsdr_decode (
  input  logic [7:0]                sensor_family,
  input  logic [7:0]                temp_offset,
  input  logic [tsdr_pkg::KB_NUM-1:0][7:0] kept,
  output logic                      family_known,
  output logic signed [15:0]        temp
);

  logic [15:0]        raw_le;
  logic [15:0]        s20_raw;
  logic [15:0]        s20_ext;
  logic [15:0]        raw;
  logic signed [21:0] r_ext;
  logic signed [21:0] prod;
  logic signed [21:0] off_ext;
  logic signed [21:0] sum;
  logic signed [21:0] quot;

  assign family_known = (sensor_family == tsdr_pkg::FAM_S20) ||
                        (sensor_family == tsdr_pkg::FAM_B20) ||
                        (sensor_family == tsdr_pkg::FAM_1822);

  assign raw_le  = {kept[tsdr_pkg::KB_MSB], kept[tsdr_pkg::KB_LSB]};
  // old part: half-degree value widened, optional count-remain extension
  assign s20_raw = raw_le << 3;
  assign s20_ext = (s20_raw & tsdr_pkg::S20_EXT_MASK) + tsdr_pkg::S20_EXT_BIAS
                   - {8'd0, kept[tsdr_pkg::KB_REM]};

  // pick raw value; newer parts drop undefined low bits per resolution
  always_comb begin
    raw = raw_le;
    if (sensor_family == tsdr_pkg::FAM_S20) begin
      raw = (kept[tsdr_pkg::KB_PER] == tsdr_pkg::S20_PER_C) ? s20_ext : s20_raw;
    end else begin
      unique case (kept[tsdr_pkg::KB_CFG][6:5])
        tsdr_pkg::RES_9BIT:  raw = raw_le & 16'hFFF8;
        tsdr_pkg::RES_10BIT: raw = raw_le & 16'hFFFC;
        tsdr_pkg::RES_11BIT: raw = raw_le & 16'hFFFE;
        default:             raw = raw_le;
      endcase
    end
  end

  // raw*25/4 + offset, rounded toward zero, then saturated
  always_comb begin
    r_ext   = 22'(signed'(raw));
    prod    = (r_ext <<< 4) + (r_ext <<< 3) + r_ext;
    off_ext = 22'(signed'({1'b0, temp_offset})) - 22'(signed'({1'b0, tsdr_pkg::OFFSET_ZERO}));
    sum     = prod + (off_ext <<< 2);
    quot    = (sum + (sum[21] ? 22'sd3 : 22'sd0)) >>> 2;
    if (quot > 22'(tsdr_pkg::TEMP_MAX)) begin
      temp = tsdr_pkg::TEMP_MAX;
    end else if (quot < 22'(tsdr_pkg::TEMP_MIN)) begin
      temp = tsdr_pkg::TEMP_MIN;
    end else begin
      temp = quot[15:0];
    end
  end

endmodule

// ===== hw/rtl/temp_scratchpad_decode_report.sv =====
// Scratchpad temperature decoder and report scheduler for one sensor channel. A request is
// either one scratchpad byte (nine make a read, checked by CRC8 and for an all-zero pad) or a
// poll carrying the current time in milliseconds. A request is taken into an input register,
// worked in one pass of logic (byte CRC update, family decode and scaling, report decision)
// and its response, if it has one, is then registered in the output register.
// One request is accepted every cycle while the response side keeps up; a response waiting
// in the output register holds the working stage whenever it holds a request, even a byte.
// There is no start-up sweep: the block takes requests straight after reset.
module temp_scratchpad_decode_report (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  tsdr_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output tsdr_pkg::rsp_t   rsp,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  // configuration
  logic [7:0]         sensor_family;
  logic [7:0]         temp_offset;
  logic [11:0]        delta10;
  logic [25:0]        min_ms;
  logic [25:0]        max_ms;
  logic signed [15:0] empty_marker;
  logic signed [15:0] error_marker;

  // channel state
  logic [3:0]                         byte_count, byte_count_next;
  logic [7:0]                         running_crc, running_crc_next;
  logic                               all_zero_seen, all_zero_seen_next;
  logic [tsdr_pkg::KB_NUM-1:0][7:0]   kept;
  logic signed [15:0]                 current_temp, current_temp_next;
  logic signed [15:0]                 last_sent_temp, last_sent_temp_next;
  logic [31:0]                        last_sent_time, last_sent_time_next;
  logic                               time_started, time_started_next;
  logic [1:0]                         retries_left, retries_left_next;
  logic                               error_reported, error_reported_next;

  // pipeline
  logic             s1_valid;
  tsdr_pkg::req_t   s1_req;
  logic             out_free;
  logic             s1_fire;
  logic             res_valid;
  tsdr_pkg::rsp_t   res;

  // working values
  logic               family_known;
  logic signed [15:0] decoded;
  logic               az;
  logic [31:0]        eff_last;
  logic [31:0]        elapsed;
  logic signed [16:0] diff;
  logic [16:0]        abs_diff;
  logic               send;

  assign out_free  = !rsp_valid || rsp_ready;
  assign s1_fire   = s1_valid && out_free;
  assign req_ready = !s1_valid || out_free;

  // configuration writes; intervals and threshold kept in working units
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_family <= tsdr_pkg::RST_FAMILY;
      temp_offset   <= tsdr_pkg::RST_OFFSET;
      delta10       <= tsdr_pkg::RST_DELTA10;
      min_ms        <= tsdr_pkg::RST_MIN_MS;
      max_ms        <= tsdr_pkg::RST_MAX_MS;
      empty_marker  <= tsdr_pkg::RST_EMPTY;
      error_marker  <= tsdr_pkg::RST_ERROR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsdr_pkg::CFG_FAMILY:  sensor_family <= cfg_data[7:0];
        tsdr_pkg::CFG_OFFSET:  temp_offset   <= cfg_data[7:0];
        tsdr_pkg::CFG_DELTA:   delta10       <= 12'(cfg_data[7:0]) * tsdr_pkg::TENTHS_PER_C;
        tsdr_pkg::CFG_MIN_INT: min_ms        <= 26'(cfg_data) * tsdr_pkg::MS_PER_S;
        tsdr_pkg::CFG_MAX_INT: max_ms        <= 26'(cfg_data) * tsdr_pkg::MS_PER_S;
        tsdr_pkg::CFG_EMPTY:   empty_marker  <= cfg_data;
        tsdr_pkg::CFG_ERROR:   error_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  tsdr_decode u_decode (
    .sensor_family (sensor_family),
    .temp_offset   (temp_offset),
    .kept          (kept),
    .family_known  (family_known),
    .temp          (decoded)
  );

  // per-request work
  always_comb begin
    byte_count_next     = byte_count;
    running_crc_next    = running_crc;
    all_zero_seen_next  = all_zero_seen;
    current_temp_next   = current_temp;
    last_sent_temp_next = last_sent_temp;
    last_sent_time_next = last_sent_time;
    time_started_next   = time_started;
    retries_left_next   = retries_left;
    error_reported_next = error_reported;
    res_valid           = 1'b0;
    res                 = '0;
    send                = 1'b0;

    az       = all_zero_seen && (s1_req.byte_value == 8'd0);
    eff_last = time_started ? last_sent_time : s1_req.now_ms;
    elapsed  = s1_req.now_ms - eff_last;
    diff     = 17'(current_temp) - 17'(last_sent_temp);
    abs_diff = diff[16] ? 17'(-diff) : 17'(diff);

    if (s1_req.func == tsdr_pkg::FUNC_BYTE) begin
      all_zero_seen_next = az;
      if (byte_count != tsdr_pkg::SP_CRC) begin
        running_crc_next = tsdr_pkg::crc8_byte(running_crc, s1_req.byte_value);
        byte_count_next  = byte_count + 4'd1;
      end else begin
        // ninth byte: check and finish the read
        res_valid = 1'b1;
        res.kind  = tsdr_pkg::KIND_READ;
        if (!family_known) begin
          current_temp_next = empty_marker;
        end else if ((running_crc != s1_req.byte_value) || az) begin
          res.read_failed = 1'b1;
          if (retries_left == 2'd0) begin
            current_temp_next = error_marker;
          end else begin
            if (retries_left == 2'd1) begin
              error_reported_next = 1'b0;
            end
            retries_left_next = retries_left - 2'd1;
          end
        end else begin
          retries_left_next = tsdr_pkg::RETRY_MAX;
          current_temp_next = decoded;
        end
        res.temperature    = current_temp_next;
        byte_count_next    = 4'd0;
        running_crc_next   = 8'd0;
        all_zero_seen_next = 1'b1;
      end
    end else begin
      // poll: the first one starts the clock
      time_started_next   = 1'b1;
      last_sent_time_next = eff_last;
      if ((current_temp != empty_marker) &&
          !((current_temp == error_marker) && error_reported) &&
          !(elapsed < 32'(min_ms))) begin
        send = ((max_ms != 26'd0) && (elapsed >= 32'(max_ms))) ||
               ((delta10 != 12'd0) && (abs_diff >= 17'(delta10)));
      end
      if (send) begin
        last_sent_temp_next = current_temp;
        last_sent_time_next = s1_req.now_ms;
        error_reported_next = 1'b1;
        res_valid           = 1'b1;
        res.kind            = tsdr_pkg::KIND_REPORT;
        res.temperature     = current_temp;
      end
    end
  end

  // channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= 4'd0;
      running_crc    <= 8'd0;
      all_zero_seen  <= 1'b1;
      current_temp   <= tsdr_pkg::RST_EMPTY;
      last_sent_temp <= tsdr_pkg::RST_EMPTY;
      last_sent_time <= 32'd0;
      time_started   <= 1'b0;
      retries_left   <= tsdr_pkg::RETRY_MAX;
      error_reported <= 1'b1;
    end else if (s1_fire) begin
      byte_count     <= byte_count_next;
      running_crc    <= running_crc_next;
      all_zero_seen  <= all_zero_seen_next;
      current_temp   <= current_temp_next;
      last_sent_temp <= last_sent_temp_next;
      last_sent_time <= last_sent_time_next;
      time_started   <= time_started_next;
      retries_left   <= retries_left_next;
      error_reported <= error_reported_next;
    end
  end

  // keep the bytes needed for decoding
  always_ff @(posedge clk) begin
    if (s1_fire && (s1_req.func == tsdr_pkg::FUNC_BYTE)) begin
      case (byte_count)
        tsdr_pkg::SP_TEMP_LSB:    kept[tsdr_pkg::KB_LSB] <= s1_req.byte_value;
        tsdr_pkg::SP_TEMP_MSB:    kept[tsdr_pkg::KB_MSB] <= s1_req.byte_value;
        tsdr_pkg::SP_CONFIG:      kept[tsdr_pkg::KB_CFG] <= s1_req.byte_value;
        tsdr_pkg::SP_COUNT_REM:   kept[tsdr_pkg::KB_REM] <= s1_req.byte_value;
        tsdr_pkg::SP_COUNT_PER_C: kept[tsdr_pkg::KB_PER] <= s1_req.byte_value;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= res_valid;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      rsp <= res;
    end
  end

endmodule

// ===== hw/rtl/tsdr_checker.sv =====
// Port-level checks for the decoder
module tsdr_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input tsdr_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tsdr_pkg::rsp_t rsp
);

  // no response straight out of reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

  // a report never flags a failed read
  a_report_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.kind == tsdr_pkg::KIND_REPORT)) |-> !rsp.read_failed)
    else $error("report carries read failure");

  // a fresh response must be preceded by an accepted request
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("response without request");

  // its kind matches that request's function
  a_rsp_kind: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> (rsp.kind == tsdr_pkg::kind_t'($past(req.func, 2))))
    else $error("response kind does not match request");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind temp_scratchpad_decode_report tsdr_checker u_tsdr_checker (.*);
